// ----- design/allowed_ip_prefix_table_top_defines.svh -----
// Assertion macros for the allowed-IP prefix table.
// Depends on nothing; sampled on clock, disabled in reset by the user site.
`ifndef ALLOWED_IP_PREFIX_TABLE_TOP_DEFINES_SVH
`define ALLOWED_IP_PREFIX_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define AIP_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define AIP_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define AIP_ASSERT_IMP(lbl, clk, rst, pre, post)
`define AIP_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif
`endif

// ----- design/aip_pkg.sv -----
// Package for the allowed-IP prefix table: request codes, states, beat types
// and the prefix mask function. Depends on nothing.
package aip_pkg;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_DELETE   = 3'd1,
      OP_DEL_PEER = 3'd2,
      OP_FIND     = 3'd3,
      OP_CLEAR    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      FAM_IPV4 = 2'd0,
      FAM_IPV6 = 2'd1
   } fam_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_SCAN, S_TAIL, S_COMMIT, S_CLEAR, S_RESP
   } state_type;

   localparam logic [7:0] V4_BITS = 8'd32;
   localparam logic [7:0] V6_BITS = 8'd128;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [1:0]  family;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [7:0]  prefix_len;
      logic [7:0]  peer_in;
   } req_beat_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [7:0] peer_out;
   } rsp_beat_type;

   // Keeps the top len bits of a 128-bit address; len at most 128.
   function automatic logic [127:0] prefix_mask(input logic [7:0] len);
      logic [7:0] sh;
      sh = V6_BITS - len;
      return {128{1'b1}} << sh;
   endfunction

endpackage

// ----- design/allowed_ip_prefix_table_top.sv -----
// Allowed-IP prefix table: longest-prefix match of IPv4/IPv6 prefixes to peers.
// Depends on aip_pkg and allowed_ip_prefix_table_top_defines.svh.
// Sequence: add and delete scan every entry, then pass the tail and commit states
// before the response strobe; find and delete-peer scan then tail; clear walks every entry;
// rejected or unused codes go straight to the response state. Busy drops after the strobe
// cycle, so one request is handled at a time. Reset clears every entry with busy high; no backpressure.
`include "allowed_ip_prefix_table_top_defines.svh"
module allowed_ip_prefix_table_top #(
   parameter int ENTRIES   = 256,
   parameter int PEER_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  aip_pkg::req_beat_type req_data,
   output logic                  rsp_strobe,
   output aip_pkg::rsp_beat_type rsp_data
);
   import aip_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

   typedef struct packed {
      logic                 valid;
      logic                 fam;
      logic [63:0]          ah;
      logic [63:0]          al;
      logic [7:0]           len;
      logic [PEER_BITS-1:0] peer;
   } entry_type;

   state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, proc_idx_ff, slot_ff, free_slot_ff;
   logic proc_vld_ff, hit_ff, free_ff, found_ff;
   logic [2:0] op_ff;
   logic fam_ff;
   logic [63:0] ah_ff, al_ff;
   logic [7:0] len_ff, best_ff;
   logic [PEER_BITS-1:0] peer_ff, hit_peer_ff, pout_ff;
   logic [1:0] status_ff;

   // entry store
   entry_type mem [ENTRIES];
   entry_type rd_q_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_q_ff <= mem[idx_ff];
   end

   // request decode at accept
   logic accept, fam_bad, len_bad, do_scan;
   logic [127:0] req_mask;
   logic [63:0] req_al;
   always_comb begin
      accept   = start && !busy;
      fam_bad  = req_data.family > FAM_IPV6;
      len_bad  = req_data.prefix_len >
                 ((req_data.family == FAM_IPV4) ? V4_BITS : V6_BITS);
      req_mask = prefix_mask(req_data.prefix_len);
      req_al   = (req_data.family == FAM_IPV4) ? 64'd0 : req_data.addr_low;
      case (req_data.req_type)
         OP_ADD, OP_DELETE: do_scan = !fam_bad && !len_bad;
         OP_FIND:           do_scan = !fam_bad;
         OP_DEL_PEER:       do_scan = 1'b1;
         default:           do_scan = 1'b0;
      endcase
   end

   // next state
   logic last;
   assign last = (idx_ff == LAST);
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT:   if (last) state_in = S_IDLE;
         S_IDLE:   if (accept) begin
            if (req_data.req_type == OP_CLEAR) state_in = S_CLEAR;
            else if (do_scan)                  state_in = S_SCAN;
            else                               state_in = S_RESP;
         end
         S_SCAN:   if (last) state_in = S_TAIL;
         S_TAIL:   state_in = (op_ff == OP_ADD || op_ff == OP_DELETE) ? S_COMMIT : S_RESP;
         S_COMMIT: state_in = S_RESP;
         S_CLEAR:  if (last) state_in = S_RESP;
         S_RESP:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // per-entry compare on the registered read
   entry_type e;
   logic [127:0] e_mask;
   logic exact, covers, peer_eq;
   always_comb begin
      e       = rd_q_ff;
      e_mask  = prefix_mask(e.len);
      exact   = e.valid && e.fam == fam_ff && e.len == len_ff &&
                e.ah == ah_ff && e.al == al_ff;
      covers  = e.valid && e.fam == fam_ff &&
                (ah_ff & e_mask[127:64]) == e.ah && (al_ff & e_mask[63:0]) == e.al;
      peer_eq = e.valid && e.peer == peer_ff;
   end

   // memory write select
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = '{valid: 1'b0, fam: fam_ff, ah: ah_ff, al: al_ff, len: len_ff,
                    peer: peer_ff};
      case (state_ff)
         S_INIT, S_CLEAR: mem_we = 1'b1;
         S_SCAN, S_TAIL: begin
            mem_waddr = proc_idx_ff;
            mem_we    = proc_vld_ff && op_ff == OP_DEL_PEER && peer_eq;
         end
         S_COMMIT: begin
            if (op_ff == OP_ADD) begin
               mem_wdata.valid = 1'b1;
               mem_waddr = hit_ff ? slot_ff : free_slot_ff;
               mem_we    = hit_ff || free_ff;
            end else begin
               mem_waddr = slot_ff;
               mem_we    = hit_ff && hit_peer_ff == peer_ff;
            end
         end
         default: mem_we = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         idx_ff      <= '0;
         proc_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         proc_vld_ff <= (state_ff == S_SCAN);
         proc_idx_ff <= idx_ff;
         if (state_ff == S_INIT || state_ff == S_SCAN || state_ff == S_CLEAR)
            idx_ff <= last ? '0 : idx_ff + 1'b1;
      end
   end

   // request and scan result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.req_type;
         fam_ff    <= req_data.family[0];
         len_ff    <= req_data.prefix_len;
         peer_ff   <= PEER_BITS'(req_data.peer_in);
         if (req_data.req_type == OP_FIND) begin
            ah_ff <= req_data.addr_high;
            al_ff <= req_al;
         end else begin
            ah_ff <= req_data.addr_high & req_mask[127:64];
            al_ff <= req_al & req_mask[63:0];
         end
         status_ff <= ((req_data.req_type == OP_ADD || req_data.req_type == OP_DELETE)
                       && (fam_bad || len_bad)) ||
                      (req_data.req_type == OP_FIND && fam_bad) ? ST_INVALID : ST_OK;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
         found_ff  <= 1'b0;
         pout_ff   <= '0;
         best_ff   <= '0;
      end else if (proc_vld_ff) begin
         if (op_ff == OP_FIND) begin
            if (covers && (!found_ff || e.len > best_ff)) begin
               found_ff <= 1'b1;
               best_ff  <= e.len;
               pout_ff  <= e.peer;
            end
         end else if (e.valid) begin
            if (!hit_ff && exact) begin
               hit_ff      <= 1'b1;
               slot_ff     <= proc_idx_ff;
               hit_peer_ff <= e.peer;
            end
         end else if (!free_ff) begin
            free_ff      <= 1'b1;
            free_slot_ff <= proc_idx_ff;
         end
      end else if (state_ff == S_COMMIT && op_ff == OP_ADD && !hit_ff && !free_ff) begin
         status_ff <= ST_FULL;
      end
   end

   // outputs
   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = (state_ff == S_RESP);
   assign rsp_data.status     = status_ff;
   assign rsp_data.found      = found_ff;
   assign rsp_data.peer_out   = 8'(pout_ff);

   // checks
   `AIP_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   `AIP_ASSERT_IMP(a_idle_after_rsp, clock, reset, $fell(busy) && $past(state_ff) != S_INIT, $past(rsp_strobe))
   `AIP_ASSERT_IMP(a_found_ok, clock, reset, rsp_strobe && rsp_data.found, rsp_data.status == ST_OK)
   `AIP_ASSERT_IMP(a_no_write_idle, clock, reset, !busy, !mem_we)

endmodule

// ----- tb/sv/aip_table_checker.sv -----
// Checker for the allowed-IP prefix table: watches request and response beats,
// keeps its own prefix store and compares each response. Depends on aip_pkg.
`timescale 1ns / 100ps
module aip_table_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  aip_pkg::req_beat_type req_data,
   input  logic                  rsp_strobe,
   input  aip_pkg::rsp_beat_type rsp_data,
   output int                    fail_count,
   output int                    pending
);
   import aip_pkg::*;

   localparam int SLOTS = 256;

   // shadow prefix store
   logic         ent_valid [SLOTS];
   logic [1:0]   ent_fam   [SLOTS];
   logic [127:0] ent_addr  [SLOTS];
   logic [7:0]   ent_len   [SLOTS];
   logic [7:0]   ent_peer  [SLOTS];

   rsp_beat_type expected_rsp_q[$];

   assign pending = expected_rsp_q.size();

   function automatic logic [127:0] keep_top(input int len);
      logic [127:0] m;
      m = '0;
      for (int b = 0; b < len; b++) m[127 - b] = 1'b1;
      return m;
   endfunction

   // Apply one request beat to the shadow store and return its answer.
   function automatic rsp_beat_type apply_request(input req_beat_type r);
      rsp_beat_type a;
      logic [127:0] addr;
      int width, best, slot, free_slot;
      bit hit, have_free;
      a = '0;
      addr = {r.addr_high, r.addr_low};
      if (r.family == FAM_IPV4) addr[63:0] = '0;
      width = (r.family == FAM_IPV4) ? 32 : 128;
      hit = 0; have_free = 0; slot = 0; free_slot = 0; best = 0;
      case (r.req_type)
         OP_ADD, OP_DELETE: begin
            if (r.family > FAM_IPV6 || r.prefix_len > width) begin
               a.status = ST_INVALID;
            end else begin
               addr &= keep_top(r.prefix_len);
               for (int i = 0; i < SLOTS; i++) begin
                  if (ent_valid[i]) begin
                     if (!hit && ent_fam[i] == r.family && ent_len[i] == r.prefix_len
                         && ent_addr[i] == addr) begin
                        hit = 1; slot = i;
                     end
                  end else if (!have_free) begin
                     have_free = 1; free_slot = i;
                  end
               end
               if (r.req_type == OP_ADD) begin
                  if (hit) ent_peer[slot] = r.peer_in;
                  else if (have_free) begin
                     ent_valid[free_slot] = 1'b1;
                     ent_fam[free_slot]   = r.family;
                     ent_addr[free_slot]  = addr;
                     ent_len[free_slot]   = r.prefix_len;
                     ent_peer[free_slot]  = r.peer_in;
                  end else a.status = ST_FULL;
               end else if (hit && ent_peer[slot] == r.peer_in) begin
                  ent_valid[slot] = 1'b0;
               end
            end
         end
         OP_DEL_PEER: begin
            for (int i = 0; i < SLOTS; i++)
               if (ent_valid[i] && ent_peer[i] == r.peer_in) ent_valid[i] = 1'b0;
         end
         OP_FIND: begin
            if (r.family > FAM_IPV6) begin
               a.status = ST_INVALID;
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (ent_valid[i] && ent_fam[i] == r.family
                      && (addr & keep_top(ent_len[i])) == ent_addr[i]
                      && (!a.found || ent_len[i] > best)) begin
                     a.found = 1'b1; best = ent_len[i]; a.peer_out = ent_peer[i];
                  end
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) ent_valid[i] = 1'b0;
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) ent_valid[i] = 1'b0;
         expected_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("outstanding beats", 1, 0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.found !== want.found)
                  report_mismatch("found", rsp_data.found, want.found);
               if (rsp_data.peer_out !== want.peer_out)
                  report_mismatch("peer_out", rsp_data.peer_out, want.peer_out);
            end
         end
         if (start && !busy) expected_rsp_q.push_back(apply_request(req_data));
      end
   end
endmodule

// ----- tb/sv/tb_allowed_ip_prefix_table_top.sv -----
// Testbench top for the allowed-IP prefix table: drives request beats with
// random gaps and gives the verdict. Depends on aip_pkg, the table top and aip_table_checker.
`timescale 1ns / 100ps
module tb_allowed_ip_prefix_table_top;
   import aip_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_beat_type req_data = '0;
   logic         rsp_strobe;
   rsp_beat_type rsp_data;
   int           fail_count;
   int           pending;

   // small pools so that adds, deletes and finds hit each other
   logic [127:0] addr_pool[8];
   logic [7:0]   peer_pool[4];

   allowed_ip_prefix_table_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   aip_table_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hand one beat over and wait for it to be taken.
   task automatic send_beat(input logic [2:0] op, input logic [1:0] fam,
                            input logic [127:0] addr, input logic [7:0] len,
                            input logic [7:0] peer);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 3);
      repeat (gap) @(posedge clock);
      req_data <= {op, fam, addr[127:64], addr[63:0], len, peer};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      start <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Random beat: mostly well-formed ops on pooled prefixes.
   task automatic send_random();
      logic [2:0] op;
      logic [1:0] fam;
      logic [127:0] addr;
      logic [7:0] len, peer;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_ADD;
      else if (pick < 55) op = OP_DELETE;
      else if (pick < 85) op = OP_FIND;
      else if (pick < 91) op = OP_DEL_PEER;
      else if (pick < 93) op = OP_CLEAR;
      else op = 3'($urandom_range(0, 7));
      fam = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      addr = addr_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 3) == 0) addr = {$urandom, $urandom, $urandom, $urandom};
      if (fam == FAM_IPV4) len = 8'($urandom_range(0, 32));
      else len = 8'($urandom_range(0, 128));
      if ($urandom_range(0, 19) == 0) len = 8'($urandom);
      peer = ($urandom_range(0, 3) == 0) ? 8'($urandom) : peer_pool[$urandom_range(0, 3)];
      send_beat(op, fam, addr, len, peer);
   endtask

   initial begin
      for (int i = 0; i < 8; i++) addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < 4; i++) peer_pool[i] = 8'($urandom);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every op, the special cases
      send_beat(OP_FIND, FAM_IPV4, '0, 8'd0, 8'd0);
      send_beat(OP_ADD, FAM_IPV4, '0, 8'd0, 8'd0);
      send_beat(OP_FIND, FAM_IPV4, '1, 8'd0, 8'd0);
      send_beat(OP_ADD, FAM_IPV4, '1, 8'd32, 8'hFF);
      send_beat(OP_FIND, FAM_IPV4, '1, 8'd0, 8'd0);
      send_beat(OP_ADD, FAM_IPV4, '1, 8'd33, 8'h11);
      send_beat(OP_ADD, 2'd2, '1, 8'd8, 8'h11);
      send_beat(OP_FIND, 2'd3, '1, 8'd8, 8'h11);
      send_beat(OP_ADD, FAM_IPV6, '1, 8'd128, 8'hA5);
      send_beat(OP_ADD, FAM_IPV6, '1, 8'd65, 8'h5A);
      send_beat(OP_FIND, FAM_IPV6, '1, 8'd0, 8'd0);
      send_beat(OP_ADD, FAM_IPV6, '1, 8'd129, 8'h01);
      send_beat(OP_ADD, FAM_IPV6, '1, 8'd255, 8'h01);
      send_beat(OP_DELETE, FAM_IPV6, '1, 8'd128, 8'h00);
      send_beat(OP_DELETE, FAM_IPV6, '1, 8'd128, 8'hA5);
      send_beat(OP_FIND, FAM_IPV6, '1, 8'd0, 8'd0);
      send_beat(OP_ADD, FAM_IPV4, {32'hC0A8_0000, {96{1'b1}}}, 8'd16, 8'h5A);
      send_beat(OP_FIND, FAM_IPV4, {32'hC0A8_1234, 96'd0}, 8'd0, 8'd0);
      send_beat(OP_DEL_PEER, FAM_IPV4, '0, 8'd0, 8'h5A);
      send_beat(OP_FIND, FAM_IPV6, '1, 8'd0, 8'd0);
      send_beat(3'd5, FAM_IPV4, '1, 8'd1, 8'h01);
      send_beat(3'd7, 2'd3, '1, 8'hFF, 8'hFF);
      send_beat(OP_CLEAR, 2'd3, '1, 8'hFF, 8'hFF);
      send_beat(OP_FIND, FAM_IPV4, '1, 8'd0, 8'd0);
      drain();

      // fill the table to its limit, then overflow it with new prefixes
      for (int i = 0; i < 258; i++)
         send_beat(OP_ADD, FAM_IPV6, {8'(i), 120'($urandom)},
                   (i < 256) ? 8'd8 : 8'd16, 8'(i));
      send_beat(OP_FIND, FAM_IPV6, {8'd200, 120'd0}, 8'd0, 8'd0);
      send_beat(OP_CLEAR, FAM_IPV4, '0, 8'd0, 8'd0);

      for (int n = 0; n < 220; n++) begin
         send_random();
         if (n == 110) drain();
      end

      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+design
design/aip_pkg.sv
design/allowed_ip_prefix_table_top.sv
tb/sv/aip_table_checker.sv
tb/sv/tb_allowed_ip_prefix_table_top.sv
